[sv/fcr_pkg.sv]
// fcr_pkg: shared widths, constants and types of the frame change rectangle block
// no dependencies; used by the interfaces and every module of the block

package fcr_pkg;

  localparam int PixW   = 32;
  localparam int CoordW = 12;
  localparam int BoxW   = 13;
  localparam int CountW = 25;
  localparam int AreaW  = 25;
  localparam int ProdW  = 2 * BoxW;

  // canvas limit, coordinates at or beyond it never count as changed
  localparam int MaxDim = 4096;

  localparam logic [PixW-1:0]   CmpMask   = 32'hfffe_fefe;
  localparam logic [PixW-1:0]   AlphaMask = 32'hff00_0000;
  localparam logic [BoxW-1:0]   CoordSent = '1;
  localparam logic [CountW-1:0] CountMax  = '1;

  // box and counters as they stand after the last beat of a frame pair
  typedef struct packed {
    logic [BoxW-1:0]   box_left;
    logic [BoxW-1:0]   box_top;
    logic [BoxW-1:0]   box_right;
    logic [BoxW-1:0]   box_bottom;
    logic [CountW-1:0] change_total;
    logic              all_opaque;
  } summary_t;

  typedef struct packed {
    logic              frame_same;
    logic              keep_previous;
    logic              rect_replaced;
    logic [CoordW-1:0] rect_left;
    logic [CoordW-1:0] rect_top;
    logic [BoxW-1:0]   rect_right;
    logic [BoxW-1:0]   rect_bottom;
    logic [CountW-1:0] changed_count;
  } result_t;

endpackage

[sv/fcr_in_if.sv]
// fcr_in_if: pixel pair channel, valid/ready handshake plus payload
// depends on fcr_pkg for field widths

interface fcr_in_if;
  logic                         valid;
  logic                         ready;
  logic [fcr_pkg::PixW-1:0]     prev_pixel;
  logic [fcr_pkg::PixW-1:0]     cur_pixel;
  logic [fcr_pkg::CoordW-1:0]   pos_x;
  logic [fcr_pkg::CoordW-1:0]   pos_y;
  logic [fcr_pkg::AreaW-1:0]    cur_area;
  logic                         last;

  modport source (
    output valid, prev_pixel, cur_pixel, pos_x, pos_y, cur_area, last,
    input  ready
  );
  modport sink (
    input  valid, prev_pixel, cur_pixel, pos_x, pos_y, cur_area, last,
    output ready
  );
endinterface

[sv/fcr_out_if.sv]
// fcr_out_if: decision channel, valid/ready handshake plus payload
// depends on fcr_pkg for field widths

interface fcr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         frame_same;
  logic                         keep_previous;
  logic                         rect_replaced;
  logic [fcr_pkg::CoordW-1:0]   rect_left;
  logic [fcr_pkg::CoordW-1:0]   rect_top;
  logic [fcr_pkg::BoxW-1:0]     rect_right;
  logic [fcr_pkg::BoxW-1:0]     rect_bottom;
  logic [fcr_pkg::CountW-1:0]   changed_count;

  modport source (
    output valid, frame_same, keep_previous, rect_replaced, rect_left, rect_top,
           rect_right, rect_bottom, changed_count,
    input  ready
  );
  modport sink (
    input  valid, frame_same, keep_previous, rect_replaced, rect_left, rect_top,
           rect_right, rect_bottom, changed_count,
    output ready
  );
endinterface

[sv/fcr_accum.sv]
// fcr_accum: per-pixel change test and running bounding box, count and opacity
// depends on fcr_pkg

module fcr_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        beat_i,
  input  logic                        last_i,
  input  logic [fcr_pkg::PixW-1:0]    prev_pixel_i,
  input  logic [fcr_pkg::PixW-1:0]    cur_pixel_i,
  input  logic [fcr_pkg::CoordW-1:0]  pos_x_i,
  input  logic [fcr_pkg::CoordW-1:0]  pos_y_i,
  output fcr_pkg::summary_t           sum_o
);

  fcr_pkg::summary_t sum_q, sum_d, upd;
  logic                       in_canvas;
  logic                       changed;
  logic [fcr_pkg::BoxW-1:0]   x_ext, y_ext, x_end, y_end;

  assign in_canvas = (32'(pos_x_i) < fcr_pkg::MaxDim) && (32'(pos_y_i) < fcr_pkg::MaxDim);
  assign changed   = in_canvas && (((prev_pixel_i ^ cur_pixel_i) & fcr_pkg::CmpMask) != '0);

  assign x_ext = fcr_pkg::BoxW'(pos_x_i);
  assign y_ext = fcr_pkg::BoxW'(pos_y_i);
  assign x_end = x_ext + fcr_pkg::BoxW'(1);
  assign y_end = y_ext + fcr_pkg::BoxW'(1);

  always_comb begin
    upd = sum_q;
    if (changed) begin
      if (x_ext < sum_q.box_left)   upd.box_left   = x_ext;
      if (y_ext < sum_q.box_top)    upd.box_top    = y_ext;
      if (x_end > sum_q.box_right)  upd.box_right  = x_end;
      if (y_end > sum_q.box_bottom) upd.box_bottom = y_end;
      if (sum_q.change_total != fcr_pkg::CountMax) begin
        upd.change_total = sum_q.change_total + fcr_pkg::CountW'(1);
      end
      if ((cur_pixel_i & fcr_pkg::AlphaMask) != fcr_pkg::AlphaMask) upd.all_opaque = 1'b0;
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (beat_i) begin
      if (last_i) begin
        sum_d.box_left     = fcr_pkg::CoordSent;
        sum_d.box_top      = fcr_pkg::CoordSent;
        sum_d.box_right    = '0;
        sum_d.box_bottom   = '0;
        sum_d.change_total = '0;
        sum_d.all_opaque   = 1'b1;
      end else begin
        sum_d = upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q.box_left     <= fcr_pkg::CoordSent;
      sum_q.box_top      <= fcr_pkg::CoordSent;
      sum_q.box_right    <= '0;
      sum_q.box_bottom   <= '0;
      sum_q.change_total <= '0;
      sum_q.all_opaque   <= 1'b1;
    end else begin
      sum_q <= sum_d;
    end
  end

  // state including the current beat, taken by the decision stage on last
  assign sum_o = upd;

endmodule

[sv/fcr_decide.sv]
// fcr_decide: box area, blend cost and rectangle decision for one frame pair
// depends on fcr_pkg

module fcr_decide (
  input  fcr_pkg::summary_t          sum_i,
  input  logic [fcr_pkg::AreaW-1:0]  cur_area_i,
  output fcr_pkg::result_t           res_o
);

  logic                        empty;
  logic [fcr_pkg::BoxW-1:0]    width, height;
  logic [fcr_pkg::ProdW-1:0]   prod, over, best;
  logic [fcr_pkg::ProdW:0]     cost;
  logic                        small_enough;

  assign empty  = sum_i.box_left >= sum_i.box_right;
  assign width  = sum_i.box_right - sum_i.box_left;
  assign height = sum_i.box_bottom - sum_i.box_top;
  assign prod   = fcr_pkg::ProdW'(width) * fcr_pkg::ProdW'(height);
  assign over   = prod - fcr_pkg::ProdW'(1);

  // a translucent change cannot be blended, cost is the full box then
  always_comb begin
    best = over;
    if (sum_i.all_opaque && (fcr_pkg::ProdW'(sum_i.change_total) < over)) begin
      best = fcr_pkg::ProdW'(sum_i.change_total);
    end
  end

  assign cost         = {1'b0, best} + (fcr_pkg::ProdW + 1)'(1);
  assign small_enough = cost < (fcr_pkg::ProdW + 1)'(cur_area_i);

  always_comb begin
    res_o               = '0;
    res_o.changed_count = sum_i.change_total;
    if (empty) begin
      res_o.frame_same    = 1'b1;
      res_o.keep_previous = 1'b1;
      res_o.rect_replaced = 1'b1;
      res_o.rect_right    = fcr_pkg::BoxW'(1);
      res_o.rect_bottom   = fcr_pkg::BoxW'(1);
    end else if (small_enough) begin
      res_o.keep_previous = 1'b1;
      res_o.rect_replaced = 1'b1;
      res_o.rect_left     = sum_i.box_left[fcr_pkg::CoordW-1:0];
      res_o.rect_top      = sum_i.box_top[fcr_pkg::CoordW-1:0];
      res_o.rect_right    = sum_i.box_right;
      res_o.rect_bottom   = sum_i.box_bottom;
    end
  end

endmodule

[sv/frame_change_rectangle_core.sv]
// frame_change_rectangle_core: top level of the frame change rectangle block
// depends on fcr_pkg, fcr_in_if, fcr_out_if, fcr_accum and fcr_decide
//
// usage
//   in_i carries one pixel pair per beat (previous and current pixel, its
//   position and the current frame's area); the beat with last set closes a
//   frame pair. out_o carries exactly one decision beat per frame pair.
// throughput
//   one pixel pair per cycle while in_i.ready is high (see stall); the running box, count and opacity flag are
//   updated by a single min/max/increment step per beat.
// decision path
//   the accepting edge of the last beat loads the summary register; once the
//   output slot frees, the area multiply and cost compare are loaded into the
//   output register, which drives out_o.
// reset
//   rst_ni clears the running state to an empty box, zero count, all opaque,
//   and drops both pipeline valids.
// stall
//   a held decision sits in the output register while a second one can wait
//   in the summary register; while both are occupied and out_o.ready is low,
//   in_i.ready is low for every beat, last or not.

module frame_change_rectangle_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcr_in_if.sink     in_i,
  fcr_out_if.source  out_o
);

  logic                        in_beat;
  logic                        last_beat;
  logic                        b_adv;
  fcr_pkg::summary_t           acc_sum;
  fcr_pkg::result_t            dec_res;

  // summary stage
  logic                        b_vld_q, b_vld_d;
  fcr_pkg::summary_t           b_sum_q;
  logic [fcr_pkg::AreaW-1:0]   b_area_q;

  // output stage
  logic                        o_vld_q, o_vld_d;
  fcr_pkg::result_t            o_res_q;

  // output slot frees when empty or being drained
  assign b_adv     = !o_vld_q || out_o.ready;
  assign in_i.ready = !b_vld_q || b_adv;
  assign in_beat   = in_i.valid && in_i.ready;
  assign last_beat = in_beat && in_i.last;

  fcr_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (in_beat),
    .last_i       (in_i.last),
    .prev_pixel_i (in_i.prev_pixel),
    .cur_pixel_i  (in_i.cur_pixel),
    .pos_x_i      (in_i.pos_x),
    .pos_y_i      (in_i.pos_y),
    .sum_o        (acc_sum)
  );

  fcr_decide u_decide (
    .sum_i      (b_sum_q),
    .cur_area_i (b_area_q),
    .res_o      (dec_res)
  );

  always_comb begin
    b_vld_d = b_vld_q;
    if (last_beat) begin
      b_vld_d = 1'b1;
    end else if (b_adv) begin
      b_vld_d = 1'b0;
    end
    o_vld_d = b_adv ? b_vld_q : o_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      b_vld_q <= b_vld_d;
      o_vld_q <= o_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (last_beat) begin
      b_sum_q  <= acc_sum;
      b_area_q <= in_i.cur_area;
    end
    if (b_adv && b_vld_q) begin
      o_res_q <= dec_res;
    end
  end

  assign out_o.valid         = o_vld_q;
  assign out_o.frame_same    = o_res_q.frame_same;
  assign out_o.keep_previous = o_res_q.keep_previous;
  assign out_o.rect_replaced = o_res_q.rect_replaced;
  assign out_o.rect_left     = o_res_q.rect_left;
  assign out_o.rect_top      = o_res_q.rect_top;
  assign out_o.rect_right    = o_res_q.rect_right;
  assign out_o.rect_bottom   = o_res_q.rect_bottom;
  assign out_o.changed_count = o_res_q.changed_count;

  // a taken last beat always lands in the summary stage
  a_last_to_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_beat |=> b_vld_q)
    else $error("last beat did not reach summary stage");

  // a waiting summary moves to the output as soon as the output slot frees
  a_summary_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && b_adv) |=> o_vld_q)
    else $error("summary not moved to output");

  // unchanged frame means zero count and a kept, replaced rectangle
  a_same_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && o_res_q.frame_same) |->
      (o_res_q.changed_count == '0 && o_res_q.keep_previous && o_res_q.rect_replaced))
    else $error("inconsistent same-frame decision");

  // keep and replace always go together
  a_keep_replace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q |-> (o_res_q.keep_previous == o_res_q.rect_replaced))
    else $error("keep_previous and rect_replaced disagree");

  // a rectangle that is not used reads as zero
  a_unused_rect_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && !o_res_q.rect_replaced) |->
      (o_res_q.rect_left == '0 && o_res_q.rect_top == '0 &&
       o_res_q.rect_right == '0 && o_res_q.rect_bottom == '0))
    else $error("unused rectangle not zero");

endmodule

[tb/sv/tb_frame_change_rectangle_core.sv]
// tb_frame_change_rectangle_core: self-checking bench for the frame change rectangle block
// depends on fcr_pkg, fcr_in_if, fcr_out_if and frame_change_rectangle_core
// streams pixel pair frames, predicts each decision and checks it under random stalls

module tb_frame_change_rectangle_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fcr_pkg::*;

  // generous ceiling on the length of the whole run
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned BeatsPerPhase = 134;
  localparam int unsigned DrainCycles = 8;

  // one pixel pair beat as the sender sees it
  typedef struct packed {
    logic [PixW-1:0]   prev_pixel;
    logic [PixW-1:0]   cur_pixel;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [AreaW-1:0]  cur_area;
    logic              last;
  } pixel_beat_t;

  // running change box per frame pair plus the queue of decisions still to come
  class decision_board;
    logic [BoxW-1:0]   left_q, top_q, right_q, bottom_q;
    logic [CountW-1:0] changed_q;
    logic              opaque_q;
    result_t           pending_decisions[$];
    int unsigned       errors;
    int unsigned       frames, same_frames, replaced_frames, plain_frames;

    function new();
      errors = 0;
      frames = 0;
      same_frames = 0;
      replaced_frames = 0;
      plain_frames = 0;
      clear_box();
    endfunction

    function void clear_box();
      left_q    = CoordSent;
      top_q     = CoordSent;
      right_q   = '0;
      bottom_q  = '0;
      changed_q = '0;
      opaque_q  = 1'b1;
    endfunction

    // accepted input beat: update the box, and on last queue the decision
    function void note_beat(pixel_beat_t b);
      logic [BoxW-1:0] x_e, y_e;
      logic [63:0]     over, blend, cost;
      result_t         r;
      x_e = {1'b0, b.pos_x};
      y_e = {1'b0, b.pos_y};
      if (int'(x_e) < MaxDim && int'(y_e) < MaxDim &&
          ((b.prev_pixel ^ b.cur_pixel) & CmpMask) != '0) begin
        if (x_e < left_q) left_q = x_e;
        if (y_e < top_q) top_q = y_e;
        if (x_e + 1'b1 > right_q) right_q = x_e + 1'b1;
        if (y_e + 1'b1 > bottom_q) bottom_q = y_e + 1'b1;
        if (changed_q < CountMax) changed_q = changed_q + 1'b1;
        if ((b.cur_pixel & AlphaMask) != AlphaMask) opaque_q = 1'b0;
      end
      if (!b.last) return;

      r = '0;
      r.changed_count = changed_q;
      if (left_q >= right_q) begin
        // nothing changed: keep the previous frame, one pixel rectangle
        r.frame_same    = 1'b1;
        r.keep_previous = 1'b1;
        r.rect_replaced = 1'b1;
        r.rect_right    = BoxW'(1);
        r.rect_bottom   = BoxW'(1);
        same_frames++;
      end else begin
        over  = (64'(bottom_q) - 64'(top_q)) * (64'(right_q) - 64'(left_q)) - 64'd1;
        blend = opaque_q ? 64'(changed_q) : 64'hffff_ffff;
        cost  = ((over < blend) ? over : blend) + 64'd1;
        if (cost < 64'(b.cur_area)) begin
          r.keep_previous = 1'b1;
          r.rect_replaced = 1'b1;
          r.rect_left     = left_q[CoordW-1:0];
          r.rect_top      = top_q[CoordW-1:0];
          r.rect_right    = right_q;
          r.rect_bottom   = bottom_q;
          replaced_frames++;
        end else begin
          plain_frames++;
        end
      end
      pending_decisions.push_back(r);
      frames++;
      clear_box();
    endfunction

    function void match_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $error("decision field %s: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    // accepted output beat: compare with the oldest queued decision
    function void check_decision(result_t got);
      result_t exp;
      if (pending_decisions.size() == 0) begin
        $error("decision beat with nothing expected");
        errors++;
        return;
      end
      exp = pending_decisions.pop_front();
      match_field("frame_same",    32'(exp.frame_same),    32'(got.frame_same));
      match_field("keep_previous", 32'(exp.keep_previous), 32'(got.keep_previous));
      match_field("rect_replaced", 32'(exp.rect_replaced), 32'(got.rect_replaced));
      match_field("rect_left",     32'(exp.rect_left),     32'(got.rect_left));
      match_field("rect_top",      32'(exp.rect_top),      32'(got.rect_top));
      match_field("rect_right",    32'(exp.rect_right),    32'(got.rect_right));
      match_field("rect_bottom",   32'(exp.rect_bottom),   32'(got.rect_bottom));
      match_field("changed_count", 32'(exp.changed_count), 32'(got.changed_count));
    endfunction

    function int unsigned waiting();
      return pending_decisions.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fcr_in_if  pix_if ();
  fcr_out_if dec_if ();

  frame_change_rectangle_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_if),
    .out_o  (dec_if)
  );

  decision_board board;
  int unsigned   src_idle_pct;
  int unsigned   sink_idle_pct;
  int unsigned   beats_sent;
  int unsigned   cycle_count;

  // clock, 12 ns period
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // every input known from time zero
  initial begin
    rst_ni            = 1'b0;
    pix_if.valid      = 1'b0;
    pix_if.prev_pixel = '0;
    pix_if.cur_pixel  = '0;
    pix_if.pos_x      = '0;
    pix_if.pos_y      = '0;
    pix_if.cur_area   = '0;
    pix_if.last       = 1'b0;
    dec_if.ready      = 1'b0;
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // decision sink: check the beat taken at this edge, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && dec_if.valid && dec_if.ready) begin
      board.check_decision('{frame_same:    dec_if.frame_same,
                             keep_previous: dec_if.keep_previous,
                             rect_replaced: dec_if.rect_replaced,
                             rect_left:     dec_if.rect_left,
                             rect_top:      dec_if.rect_top,
                             rect_right:    dec_if.rect_right,
                             rect_bottom:   dec_if.rect_bottom,
                             changed_count: dec_if.changed_count});
    end
    dec_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // push one pixel pair beat, idling before it at the sender's rate
  task automatic send_beat(input pixel_beat_t b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid      <= 1'b1;
    pix_if.prev_pixel <= b.prev_pixel;
    pix_if.cur_pixel  <= b.cur_pixel;
    pix_if.pos_x      <= b.pos_x;
    pix_if.pos_y      <= b.pos_y;
    pix_if.cur_area   <= b.cur_area;
    pix_if.last       <= b.last;
    // hold until the block takes it
    do @(posedge clk_i); while (!pix_if.ready);
    board.note_beat(b);
    beats_sent++;
  endtask

  task automatic beat(input logic [PixW-1:0] prev, input logic [PixW-1:0] cur,
                      input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                      input logic [AreaW-1:0] area, input logic last);
    send_beat('{prev_pixel: prev, cur_pixel: cur, pos_x: x, pos_y: y,
                cur_area: area, last: last});
  endtask

  // area of the current frame on the closing beat, biased toward the cost boundary
  function automatic logic [AreaW-1:0] pick_area();
    case ($urandom_range(0, 3))
      0:       return AreaW'($urandom_range(0, 80));
      1:       return AreaW'($urandom());
      2:       return AreaW'($urandom_range(1, 16777216));
      default: return AreaW'($urandom_range(0, 3));
    endcase
  endfunction

  // one random frame pair, mostly short and confined to a small window
  task automatic random_frame();
    int unsigned     n, chg_pct;
    bit              window, opaque_frame, do_change;
    logic [CoordW-1:0] bx, by;
    pixel_beat_t     b;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    window = ($urandom_range(0, 3) != 0);
    bx = CoordW'($urandom_range(0, 4088));
    by = CoordW'($urandom_range(0, 4088));
    case ($urandom_range(0, 3))
      0:       chg_pct = 0;
      1:       chg_pct = 20;
      2:       chg_pct = 60;
      default: chg_pct = 100;
    endcase
    opaque_frame = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < int'(n); i++) begin
      b.prev_pixel = $urandom();
      if (opaque_frame) b.prev_pixel[31:24] = 8'hff;
      do_change = ($urandom_range(0, 99) < chg_pct);
      if (do_change) begin
        case ($urandom_range(0, 2))
          0:       b.cur_pixel = $urandom();
          1:       b.cur_pixel = b.prev_pixel ^ (32'h1 << $urandom_range(0, 31));
          default: b.cur_pixel = b.prev_pixel ^ $urandom();
        endcase
      end else begin
        // only the ignored low bits of the color channels differ
        b.cur_pixel = b.prev_pixel ^ ($urandom() & 32'h0001_0101);
      end
      if (opaque_frame) b.cur_pixel[31:24] = 8'hff;
      if (window) begin
        b.pos_x = bx + CoordW'($urandom_range(0, 7));
        b.pos_y = by + CoordW'($urandom_range(0, 7));
      end else begin
        b.pos_x = CoordW'($urandom());
        b.pos_y = CoordW'($urandom());
      end
      b.last = (i == int'(n) - 1);
      b.cur_area = b.last ? pick_area() : AreaW'($urandom());
      send_beat(b);
    end
  endtask

  initial begin
    board         = new();
    src_idle_pct  = 9;
    sink_idle_pct = 68;
    beats_sent    = 0;
    cycle_count   = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames
    // lone closing beat, no change at all
    beat(32'h1234_5678, 32'h1234_5678, 12'd5, 12'd5, 25'd1, 1'b1);
    // difference only in the ignored color low bits
    beat(32'hff00_0000, 32'hff01_0101, 12'd7, 12'd9, 25'd100, 1'b1);
    // one opaque change at the origin, area just above the cost
    beat(32'hff00_0000, 32'hff00_0002, 12'd0, 12'd0, 25'd2, 1'b1);
    // same but cost equals area
    beat(32'hff00_0000, 32'hff00_0002, 12'd0, 12'd0, 25'd1, 1'b1);
    // far corner, translucent, widest area
    beat(32'h0000_0000, 32'hfeff_ffff, 12'd4095, 12'd4095, 25'h1ff_ffff, 1'b1);
    // change with zero area never wins
    beat(32'hffff_ffff, 32'h0000_0000, 12'd100, 12'd200, 25'd0, 1'b1);
    // alpha low bit counts as a change, and makes it translucent
    beat(32'hff00_0000, 32'hfe00_0000, 12'd3, 12'd4, 25'd50, 1'b1);
    // full canvas box, opaque: blend cost wins
    beat(32'hff00_0000, 32'hffff_ffff, 12'd0, 12'd0, 25'd0, 1'b0);
    beat(32'hff00_0000, 32'hffff_ffff, 12'd4095, 12'd4095, 25'd0, 1'b0);
    beat(32'h0, 32'h0, 12'd10, 12'd10, 25'h100_0000, 1'b1);
    // full canvas box, translucent: box cost equals the area
    beat(32'hff00_0000, 32'h00ff_ffff, 12'd0, 12'd0, 25'd0, 1'b0);
    beat(32'hff00_0000, 32'hffff_ffff, 12'd4095, 12'd4095, 25'd0, 1'b0);
    beat(32'h0, 32'h0, 12'd10, 12'd10, 25'h100_0000, 1'b1);
    // same box, area one larger
    beat(32'hff00_0000, 32'h00ff_ffff, 12'd0, 12'd0, 25'd0, 1'b0);
    beat(32'hff00_0000, 32'hffff_ffff, 12'd4095, 12'd4095, 25'd0, 1'b0);
    beat(32'h0, 32'h0, 12'd10, 12'd10, 25'h100_0001, 1'b1);
    // short row, last beat also changed
    beat(32'hff11_2233, 32'hff11_2235, 12'd20, 12'd30, 25'd0, 1'b0);
    beat(32'hff11_2233, 32'hff13_2233, 12'd21, 12'd30, 25'd0, 1'b0);
    beat(32'hff11_2233, 32'hff11_4233, 12'd22, 12'd31, 25'd6, 1'b1);

    // random phases: sender mostly busy, then receiver mostly busy, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 9;  sink_idle_pct = 68; end
        1: begin src_idle_pct = 68; sink_idle_pct = 9;  end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      begin
        int unsigned start_beats;
        start_beats = beats_sent;
        while (beats_sent - start_beats < BeatsPerPhase) random_frame();
      end
    end
    pix_if.valid <= 1'b0;

    // drain outstanding decisions, then let the block sit quiet
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d pixel beats over %0d frame pairs", beats_sent, board.frames);
    $display("decisions: %0d unchanged, %0d change box, %0d frame kept as is",
             board.same_frames, board.replaced_frames, board.plain_frames);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
